/* rtl/scd_pkg.sv */
`timescale 1ns / 1ps

package scd_pkg;

  // Line layout
  localparam int COMMAND_LEN = 4;
  localparam int VALUE_LEN   = 4;
  localparam int POS_LIMIT   = COMMAND_LEN + VALUE_LEN + 1;
  localparam int POS_W       = $clog2(POS_LIMIT + 1);
  localparam int CMD_IDX_W   = $clog2(COMMAND_LEN);
  localparam int VAL_IDX_W   = $clog2(VALUE_LEN);

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 4;
  localparam int VALUE_W = 15;
  localparam int GAIN_W  = 8;
  // Parsed magnitude of a full value buffer plus sign
  localparam int ACC_W   = $clog2(10 ** VALUE_LEN) + 1;

  // Range checks and register reset
  localparam int RPM_MAX   = 4000;
  localparam int CUT_MIN   = 20;
  localparam int CUT_RESET = 65;

  // Decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Special characters
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [CODE_W-1:0] {
    CMD_NONE = 4'd0,
    CMD_CUTH = 4'd1,
    CMD_HOME = 4'd2,
    CMD_CALI = 4'd3,
    CMD_MOTO = 4'd4,
    CMD_MRPM = 4'd5,
    CMD_MDIR = 4'd6,
    CMD_PIDP = 4'd7,
    CMD_PIDI = 4'd8,
    CMD_PIDD = 4'd9,
    CMD_PRNT = 4'd10
  } cmd_e;

  localparam int NUM_CMDS = 10;

  // Index k holds the name of command code k+1, first character in the MSBs
  localparam logic [NUM_CMDS-1:0][COMMAND_LEN*BYTE_W-1:0] CMD_NAMES = {
    "PRNT", "PIDD", "PIDI", "PIDP", "MDIR", "MRPM", "MOTO", "CALI", "HOME", "CUTH"
  };

  // One finished line, handed from the front to the back
  typedef struct packed {
    cmd_e                                code;
    logic [VALUE_LEN-1:0]                value_valid;
    logic [VALUE_LEN-1:0][BYTE_W-1:0]    value_chars;
  } scd_entry_t;

endpackage

/* rtl/scd_front.sv */
`timescale 1ns / 1ps

module scd_front import scd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              push_o,
  output scd_entry_t        entry_o
);

  logic [POS_W-1:0]                   pos_q, pos_d, pos_inc;
  logic [COMMAND_LEN-1:0][BYTE_W-1:0] cmd_chars_q, cmd_chars_d;
  logic [VALUE_LEN-1:0][BYTE_W-1:0]   val_chars_q, val_chars_d;
  logic [COMMAND_LEN*BYTE_W-1:0]      cmd_word;
  logic [POS_W-1:0]                   val_pos;
  logic                               is_newline;
  cmd_e                               match_code;

  assign is_newline = (rx_byte_i == CHAR_NEWLINE);
  assign val_pos    = pos_q - POS_W'(COMMAND_LEN);

  // Store the byte at its line position, saturate the position, restart it on a newline
  always_comb begin
    cmd_chars_d = cmd_chars_q;
    val_chars_d = val_chars_q;
    if (pos_q < POS_W'(COMMAND_LEN)) begin
      cmd_chars_d[pos_q[CMD_IDX_W-1:0]] = rx_byte_i;
    end else if (pos_q < POS_W'(COMMAND_LEN + VALUE_LEN)) begin
      val_chars_d[val_pos[VAL_IDX_W-1:0]] = rx_byte_i;
    end
    pos_inc = (pos_q < POS_W'(POS_LIMIT)) ? pos_q + POS_W'(1) : pos_q;
    pos_d   = is_newline ? '0 : pos_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
    end
  end

  // Buffers are not reset; only characters of the current line are used
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_chars_q <= cmd_chars_d;
      val_chars_q <= val_chars_d;
    end
  end

  // Command match needs a full command buffer
  always_comb begin
    for (int j = 0; j < COMMAND_LEN; j++) begin
      cmd_word[(COMMAND_LEN-1-j)*BYTE_W +: BYTE_W] = cmd_chars_d[j];
    end
    match_code = CMD_NONE;
    if (pos_inc >= POS_W'(COMMAND_LEN)) begin
      for (int k = 0; k < NUM_CMDS; k++) begin
        if (cmd_word == CMD_NAMES[k]) begin
          match_code = cmd_e'(CODE_W'(k + 1));
        end
      end
    end
  end

  // Classified line goes to the queue on the newline transfer
  always_comb begin
    entry_o.code        = match_code;
    entry_o.value_chars = val_chars_d;
    for (int i = 0; i < VALUE_LEN; i++) begin
      entry_o.value_valid[i] = (pos_inc > POS_W'(COMMAND_LEN + i));
    end
  end

  assign push_o = accept_i && is_newline;

endmodule

/* rtl/scd_queue.sv */
`timescale 1ns / 1ps

module scd_queue import scd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  scd_entry_t entry_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       head_valid_o,
  output scd_entry_t head_o
);

  scd_entry_t        slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/scd_back.sv */
`timescale 1ns / 1ps

module scd_back import scd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [BYTE_W-1:0]        cfg_wdata_i,
  input  logic                     head_valid_i,
  input  scd_entry_t               head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CODE_W-1:0]        command_code_o,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                     accepted_o,
  output logic signed [GAIN_W-1:0] gain_mantissa_o,
  output logic signed [GAIN_W-1:0] gain_exponent_o
);

  localparam int WIDE_W = (ACC_W > VALUE_W) ? ACC_W : VALUE_W;
  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(2 ** (VALUE_W - 1) - 1);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = WIDE_W'(-(2 ** (VALUE_W - 1)));
  localparam logic signed [ACC_W-1:0]  RPM_LOW = ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  RPM_LIM = ACC_W'(RPM_MAX);
  localparam logic signed [ACC_W-1:0]  CUT_LIM = ACC_W'(CUT_MIN);

  logic [BYTE_W-1:0]                max_cut_q;
  logic                             out_valid_q;
  cmd_e                             code_q;
  logic signed [VALUE_W-1:0]        value_q;
  logic                             accepted_q;
  logic signed [GAIN_W-1:0]         mant_q, expo_q;

  logic signed [ACC_W-1:0]          value_full, mant_full, expo_full;
  logic signed [WIDE_W-1:0]         value_wide, value_sat;
  logic [VALUE_LEN-1:0][BYTE_W-1:0] mant_chars, expo_chars;
  logic [VALUE_LEN-1:0]             mant_valid, expo_valid;
  logic                             accepted_d;

  // atol over the buffered characters; a missing character ends the parse
  function automatic logic signed [ACC_W-1:0] parse_atol(
    input logic [VALUE_LEN-1:0][BYTE_W-1:0] chars,
    input logic [VALUE_LEN-1:0]             valid
  );
    logic [ACC_W-1:0]  acc;
    logic              neg;
    logic              in_digits;
    logic              done;
    logic [BYTE_W-1:0] c;
    logic              is_space;
    logic              is_digit;
    acc       = '0;
    neg       = 1'b0;
    in_digits = 1'b0;
    done      = 1'b0;
    for (int i = 0; i < VALUE_LEN; i++) begin
      c        = chars[i];
      is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
      if (!valid[i]) begin
        done = 1'b1;
      end else if (!done) begin
        if (!in_digits) begin
          if (is_space) begin
            in_digits = 1'b0;
          end else if (c == 8'h2B || c == 8'h2D) begin
            neg       = (c == 8'h2D);
            in_digits = 1'b1;
          end else if (is_digit) begin
            acc       = ACC_W'(c[3:0]);
            in_digits = 1'b1;
          end else begin
            done = 1'b1;
          end
        end else if (is_digit) begin
          acc = (acc << 3) + (acc << 1) + ACC_W'(c[3:0]);
        end else begin
          done = 1'b1;
        end
      end
    end
    return neg ? -$signed(acc) : $signed(acc);
  endfunction

  // Cut height limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cut_q <= BYTE_W'(CUT_RESET);
    end else if (cfg_we_i) begin
      max_cut_q <= cfg_wdata_i;
    end
  end

  // Gain halves: value characters 0-1 and 2-3
  always_comb begin
    mant_chars    = '0;
    expo_chars    = '0;
    mant_valid    = '0;
    expo_valid    = '0;
    mant_chars[0] = head_i.value_chars[0];
    mant_chars[1] = head_i.value_chars[1];
    expo_chars[0] = head_i.value_chars[2];
    expo_chars[1] = head_i.value_chars[3];
    mant_valid[0] = head_i.value_valid[0];
    mant_valid[1] = head_i.value_valid[1];
    expo_valid[0] = head_i.value_valid[2];
    expo_valid[1] = head_i.value_valid[3];
  end

  assign value_full = parse_atol(head_i.value_chars, head_i.value_valid);
  assign mant_full  = parse_atol(mant_chars, mant_valid);
  assign expo_full  = parse_atol(expo_chars, expo_valid);

  // Saturate the reported value
  always_comb begin
    value_wide = WIDE_W'(value_full);
    if (value_wide > SAT_MAX) begin
      value_sat = SAT_MAX;
    end else if (value_wide < SAT_MIN) begin
      value_sat = SAT_MIN;
    end else begin
      value_sat = value_wide;
    end
  end

  // Per-command range check on the full value
  always_comb begin
    unique case (head_i.code) inside
      CMD_CUTH: accepted_d = (value_full >= CUT_LIM) &&
                             (value_full <= $signed({1'b0, max_cut_q}));
      CMD_HOME, CMD_CALI, CMD_MOTO, CMD_PRNT:
                accepted_d = (value_full == ACC_W'(1));
      CMD_MRPM: accepted_d = (value_full >= RPM_LOW) && (value_full <= RPM_LIM);
      CMD_MDIR: accepted_d = (value_full == ACC_W'(0)) || (value_full == ACC_W'(1));
      CMD_PIDP, CMD_PIDI, CMD_PIDD:
                accepted_d = 1'b1;
      default:  accepted_d = 1'b0;
    endcase
  end

  // Output register, refilled when empty or when its transfer completes
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      code_q     <= head_i.code;
      value_q    <= VALUE_W'(value_sat);
      accepted_q <= accepted_d;
      mant_q     <= GAIN_W'(mant_full);
      expo_q     <= GAIN_W'(expo_full);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_code_o  = code_q;
  assign value_o         = value_q;
  assign accepted_o      = accepted_q;
  assign gain_mantissa_o = mant_q;
  assign gain_exponent_o = expo_q;

`ifndef NO_ASSERTIONS
  a_none_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (code_q == CMD_NONE) |-> !accepted_q)
    else $error("unknown command reported as accepted");

  a_rpm_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && accepted_q && (code_q == CMD_MRPM) |->
      (value_q >= VALUE_W'(1)) && (value_q <= VALUE_W'(RPM_MAX)))
    else $error("accepted MRPM outside its range");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped entry did not reach the output register");
`endif

endmodule

/* rtl/serial_command_decoder.sv */
`timescale 1ns / 1ps

// Line-oriented serial command decoder.
// Input channel: one received ASCII byte per transfer (in_valid_i/in_stall_o,
// rx_byte_i). Bytes 0-3 of a line form the command, bytes 4-7 the value; later
// bytes are dropped. A newline byte ends the line.
// Output channel: one result per newline (out_valid_o/out_stall_i) with the
// command code, the atol-parsed value, the range-check flag and the two gain
// halves. Other bytes produce no result.
// Config: cfg_we_i writes cfg_wdata_i into the cut height limit (reset 65 mm).
// Throughput: one byte per cycle while in_stall_o is low. The front stores
// bytes and matches the command; a two-entry line queue feeds the back, which
// parses and checks the value and registers the result.
// A finished line is written into the queue; from the queue head it is loaded
// into the output register when that register is empty or its transfer completes.
// Reset clears the line position, the queue and the output valid and loads the
// default cut height limit. While the receiver stalls, the result holds; the
// input keeps taking bytes until the queue is full, then in_stall_o rises.
module serial_command_decoder import scd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [BYTE_W-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [BYTE_W-1:0]         rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [CODE_W-1:0]         command_code_o,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      accepted_o,
  output logic signed [GAIN_W-1:0]  gain_mantissa_o,
  output logic signed [GAIN_W-1:0]  gain_exponent_o
);

  logic       accept;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       head_valid;
  scd_entry_t push_entry;
  scd_entry_t head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  scd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  scd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  scd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .command_code_o  (command_code_o),
    .value_o         (value_o),
    .accepted_o      (accepted_o),
    .gain_mantissa_o (gain_mantissa_o),
    .gain_exponent_o (gain_exponent_o)
  );

endmodule
